FILE: rtl/core/sfc_pkg.sv
// Shared types and constants for the sphere frustum culling block.
`timescale 1ns / 1ps

package sfc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int MAX_BATCH  = 65536;
  localparam int CNT_W      = 17;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W  = 3;

  // widths of the plane datapath
  localparam int COORD_W = 24;
  localparam int RAD_W   = 23;
  localparam int NRM_W   = 13;
  localparam int OFF_W   = 25;
  localparam int ALIGN_SH = 12;
  localparam int PROD_W  = NRM_W + COORD_W;   // 37
  localparam int SUM_W   = PROD_W + 2;        // three products
  localparam int BIAS_W  = OFF_W + ALIGN_SH + 1;
  localparam int TOT_W   = SUM_W + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BATCH);

  typedef logic [63:0] plane_t;

  // what the classifier leaves for the counting stage
  typedef struct packed {
    logic vis;
    logic last;
  } sfc_result_t;

endpackage

FILE: rtl/core/sfc_front.sv
// Front end: plane registers, plane test pipeline and input flow control.
`timescale 1ns / 1ps

module sfc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sfc_pkg::COORD_W-1:0] in_centre_x,
  input  logic signed [sfc_pkg::COORD_W-1:0] in_centre_y,
  input  logic signed [sfc_pkg::COORD_W-1:0] in_centre_z,
  input  logic [sfc_pkg::RAD_W-1:0]         in_sphere_radius,
  input  logic                              in_batch_end,
  input  logic [sfc_pkg::QCNT_W-1:0]        q_level,
  output logic                              push,
  output sfc_pkg::sfc_result_t              push_data
);

  localparam int NP = sfc_pkg::NUM_PLANES;

  sfc_pkg::plane_t plane_r [NP];

  logic                               acc;
  logic                               v1_r, v2_r;
  logic                               last1_r, last2_r;
  logic signed [sfc_pkg::PROD_W-1:0]  prod_nxt [NP][3];
  logic signed [sfc_pkg::PROD_W-1:0]  prod_r   [NP][3];
  logic signed [sfc_pkg::BIAS_W-1:0]  bias_nxt [NP];
  logic signed [sfc_pkg::BIAS_W-1:0]  bias1_r  [NP];
  logic signed [sfc_pkg::BIAS_W-1:0]  bias2_r  [NP];
  logic signed [sfc_pkg::SUM_W-1:0]   sum_r    [NP];
  logic signed [sfc_pkg::TOT_W-1:0]   tot      [NP];
  logic [NP-1:0]                      keep;
  logic [sfc_pkg::QCNT_W:0]           credit_used;

  // plane registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NP; i++) plane_r[i] <= '0;
    end else if (cfg_valid && (cfg_index < sfc_pkg::CFG_IDX_W'(NP))) begin
      plane_r[cfg_index] <= cfg_data;
    end
  end

  // a slot in the queue is reserved for every item in flight
  assign credit_used = (sfc_pkg::QCNT_W + 1)'(q_level) + (sfc_pkg::QCNT_W + 1)'(v1_r)
                     + (sfc_pkg::QCNT_W + 1)'(v2_r);
  assign in_stall = credit_used >= (sfc_pkg::QCNT_W + 1)'(sfc_pkg::QDEPTH);
  assign acc      = in_valid && !in_stall;

  // stage 1: eighteen products, offset and radius aligned by a 12-bit left shift
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      prod_nxt[p][0] = $signed(plane_r[p][12:0])  * in_centre_x;
      prod_nxt[p][1] = $signed(plane_r[p][25:13]) * in_centre_y;
      prod_nxt[p][2] = $signed(plane_r[p][38:26]) * in_centre_z;
      bias_nxt[p] = sfc_pkg::BIAS_W'($signed({plane_r[p][63:39], 12'b0}))
                  + $signed(sfc_pkg::BIAS_W'({in_sphere_radius, 12'b0}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prod_r  <= prod_nxt;
      bias1_r <= bias_nxt;
      last1_r <= in_batch_end;
    end
    // stage 2: dot products
    for (int p = 0; p < NP; p++) begin
      sum_r[p] <= sfc_pkg::SUM_W'(prod_r[p][0]) + sfc_pkg::SUM_W'(prod_r[p][1])
                + sfc_pkg::SUM_W'(prod_r[p][2]);
    end
    bias2_r <= bias1_r;
    last2_r <= last1_r;
  end

  // culled when dot + offset + radius is negative on any plane
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      tot[p]  = sfc_pkg::TOT_W'(sum_r[p]) + sfc_pkg::TOT_W'(bias2_r[p]);
      keep[p] = !tot[p][sfc_pkg::TOT_W-1];
    end
  end

  assign push           = v2_r;
  assign push_data.vis  = &keep;
  assign push_data.last = last2_r;

endmodule

FILE: rtl/core/sfc_queue.sv
// Small queue decoupling the plane test from the batch counter.
`timescale 1ns / 1ps

module sfc_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  sfc_pkg::sfc_result_t        push_data,
  input  logic                        pop,
  output logic                        q_valid,
  output sfc_pkg::sfc_result_t        q_data,
  output logic [sfc_pkg::QCNT_W-1:0]  q_level
);

  sfc_pkg::sfc_result_t              mem_r [sfc_pkg::QDEPTH];
  logic [sfc_pkg::QPTR_W-1:0]        wr_r, rd_r;
  logic [sfc_pkg::QCNT_W-1:0]        cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + sfc_pkg::QCNT_W'(push) - sfc_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  assign q_valid = cnt_r != '0;
  assign q_data  = mem_r[rd_r];
  assign q_level = cnt_r;

endmodule

FILE: rtl/core/sfc_back.sv
// Back end: visible counter per batch and the result register.
`timescale 1ns / 1ps

module sfc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  sfc_pkg::sfc_result_t       q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_visible,
  output logic [sfc_pkg::CNT_W-1:0]  out_visible_total,
  output logic                       out_batch_done
);

  logic                       out_valid_r;
  logic                       vis_r, done_r;
  logic [sfc_pkg::CNT_W-1:0]  total_r, cnt_r, total_nxt;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  // saturating count of visible spheres
  assign total_nxt = (q_data.vis && (cnt_r < sfc_pkg::CNT_MAX)) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        cnt_r       <= q_data.last ? '0 : total_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      vis_r   <= q_data.vis;
      total_r <= total_nxt;
      done_r  <= q_data.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_visible       = vis_r;
  assign out_visible_total = total_r;
  assign out_batch_done    = done_r;

endmodule

FILE: rtl/core/sphere_frustum_cull.sv
// Top level of the six-plane bounding sphere frustum culling block.
// One sphere per cycle is taken and one result per cycle is given for as long as neither
// side stalls. The eighteen normal-by-centre products are formed in the first pipeline
// stage, the three per plane are summed in the second, and the offset plus radius test
// with the six-way AND lands the verdict in a four-entry queue. The back end pops the
// queue into the result register, updating the batch counter on the way. in_stall is raised
// while the queue plus the two pipeline stages hold four items; a stalled output therefore
// backs up into the input after five spheres (four queued, one in the result register),
// never dropping any. The counter saturates at MAX_BATCH and clears after the sphere
// flagged batch_end. Plane registers are written through the cfg port (cfg_ready is
// always high; indices six and seven are ignored) and must only be changed while no
// sphere is in flight.
`timescale 1ns / 1ps

module sphere_frustum_cull (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                        cfg_data,
  // sphere input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [sfc_pkg::COORD_W-1:0] in_centre_x,
  input  logic signed [sfc_pkg::COORD_W-1:0] in_centre_y,
  input  logic signed [sfc_pkg::COORD_W-1:0] in_centre_z,
  input  logic [sfc_pkg::RAD_W-1:0]          in_sphere_radius,
  input  logic                               in_batch_end,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_visible,
  output logic [sfc_pkg::CNT_W-1:0]          out_visible_total,
  output logic                               out_batch_done
);

  logic                        push, pop, q_valid;
  sfc_pkg::sfc_result_t        push_data, q_data;
  logic [sfc_pkg::QCNT_W-1:0]  q_level;

  // config is always accepted
  assign cfg_ready = 1'b1;

  sfc_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_centre_x      (in_centre_x),
    .in_centre_y      (in_centre_y),
    .in_centre_z      (in_centre_z),
    .in_sphere_radius (in_sphere_radius),
    .in_batch_end     (in_batch_end),
    .q_level          (q_level),
    .push             (push),
    .push_data        (push_data)
  );

  sfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_level   (q_level)
  );

  sfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_visible       (out_visible),
    .out_visible_total (out_visible_total),
    .out_batch_done    (out_batch_done)
  );

endmodule

FILE: rtl/core/sfc_checker.sv
// Port-level checks for the sphere frustum culling block, bound to the top level.
`timescale 1ns / 1ps

module sfc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_visible,
  input logic [sfc_pkg::CNT_W-1:0]         out_visible_total,
  input logic                              out_batch_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_visible)
      && $stable(out_visible_total) && $stable(out_batch_done))
    else $error("stalled result changed");

  // a visible sphere is counted in its own result
  a_vis_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_visible |-> out_visible_total != '0)
    else $error("visible sphere not counted");

  // the count never passes the batch limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_visible_total <= sfc_pkg::CNT_MAX)
    else $error("visible count above limit");

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // config port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

endmodule

bind sphere_frustum_cull sfc_checker u_sfc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_visible       (out_visible),
  .out_visible_total (out_visible_total),
  .out_batch_done    (out_batch_done)
);
